// ===== src/csfs_pkg.sv =====
// ----------------------------------------------------------------------------
// csfs_pkg: shared types and constants for the coil segment field sum block
// Item layouts, store sizing, fixed-point limits and controller interface.
// ----------------------------------------------------------------------------
package csfs_pkg;

  // coil store sizing
  localparam int NUM_COILS         = 12;
  localparam int SEGMENTS_PER_COIL = 256;
  localparam int VERTS_PER_COIL    = SEGMENTS_PER_COIL + 1;
  localparam int STORE_DEPTH       = NUM_COILS * VERTS_PER_COIL;
  localparam int ADDR_W            = $clog2(STORE_DEPTH + 1);
  localparam int SEG_W             = $clog2(SEGMENTS_PER_COIL);
  localparam int COIL_W            = (NUM_COILS > 1) ? $clog2(NUM_COILS) : 1;

  // fixed-point constants
  localparam logic [63:0] Q_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] P2_13   = 64'h0000_0000_0000_2000;
  localparam logic [63:0] P2_26   = 64'h0000_0000_0400_0000;
  localparam logic [63:0] P2_30   = 64'h0000_0000_4000_0000;
  localparam logic [63:0] P2_40   = 64'h0000_0100_0000_0000;
  localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] OUT_MIN = -64'sh0000_8000_0000_0000;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // norm select codes
  localparam logic [1:0] NSEL_LEN = 2'd0;
  localparam logic [1:0] NSEL_A   = 2'd1;
  localparam logic [1:0] NSEL_B   = 2'd2;

  // per-component divide chain stages
  localparam logic [2:0] STG_A     = 3'd0;
  localparam logic [2:0] STG_B     = 3'd1;
  localparam logic [2:0] STG_SCALE = 3'd2;
  localparam logic [2:0] STG_T     = 3'd3;
  localparam logic [2:0] STG_DSL   = 3'd4;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         coil_number;
    logic [8:0]         vertex_number;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] field_x;
    logic signed [47:0] field_y;
    logic signed [47:0] field_z;
    logic               status;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vertex_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       query;
    logic       rd_next;
    logic       latch_v0;
    logic       latch_v1;
    logic       diff;
    logic       mul_en;
    logic [3:0] mul_k;
    logic       sq_start;
    logic [1:0] sq_sel;
    logic       md_start;
    logic       md_tcalc;
    logic [1:0] md_comp;
    logic [2:0] md_stage;
    logic       mark_sing;
    logic       adv;
    logic       adv_skip;
    logic       finish;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sq_done;
    logic md_done;
    logic sing_now;
  } dp_status_t;

  // difference of two Q4.28 values cut to Q6.26, magnitude truncated
  function automatic logic signed [31:0] to_q26(input logic signed [32:0] d);
    logic [32:0] mag;
    logic [31:0] sh;
    mag = d[32] ? 33'(-d) : 33'(d);
    sh  = 32'(mag >> 2);
    return d[32] ? -$signed(sh) : $signed(sh);
  endfunction

  // saturating signed add, overflow flag in the top bit
  function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? {1'b1, 64'h8000_0000_0000_0000} : {1'b1, Q_LIMIT};
    end
    return {1'b0, s};
  endfunction

  // clamp to the 48-bit output range, overflow flag in the top bit
  function automatic logic [48:0] clamp_out(input logic signed [63:0] v);
    if (v > OUT_MAX) begin
      return {1'b1, OUT_MAX[47:0]};
    end
    if (v < OUT_MIN) begin
      return {1'b1, OUT_MIN[47:0]};
    end
    return {1'b0, v[47:0]};
  endfunction

endpackage

// ===== src/csfs_isqrt.sv =====
// ----------------------------------------------------------------------------
// csfs_isqrt: iterative floor square root
// 64-bit radicand, 32-bit root, one result bit per cycle, then a done state.
// ----------------------------------------------------------------------------
module csfs_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [63:0] v_q, v_d;
  logic [63:0] r_q, r_d;
  logic [63:0] bit_q, bit_d;
  logic [63:0] trial;

  assign trial = r_q + bit_q;

  // one digit step per cycle
  always_comb begin
    state_d = state_q;
    v_d     = v_q;
    r_d     = r_q;
    bit_d   = bit_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          v_d     = value_i;
          r_d     = '0;
          bit_d   = 64'h4000_0000_0000_0000;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (v_q >= trial) begin
          v_d = v_q - trial;
          r_d = (r_q >> 1) + bit_q;
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          state_d = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign done_o = (state_q == S_DONE);
  assign root_o = r_q[31:0];

endmodule

// ===== src/csfs_muldiv.sv =====
// ----------------------------------------------------------------------------
// csfs_muldiv: floor(x * y / z) with a 128-bit product, saturating at 2^63-1
// Shift-add multiply, then a restoring divide pass,
// or a single shift when z is a known power of two.
// ----------------------------------------------------------------------------
module csfs_muldiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  input  logic [63:0] y_i,
  input  logic [63:0] z_i,
  input  logic        pow2_i,
  input  logic [5:0]  shift_i,
  output logic        done_o,
  output logic [63:0] q_o,
  output logic        ovf_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [63:0] Q_LIMIT_L = csfs_pkg::Q_LIMIT;

  logic [2:0]   state_q, state_d;
  logic [5:0]   cnt_q, cnt_d;
  logic [127:0] p_q, p_d;
  logic [63:0]  x_q, x_d;
  logic [63:0]  z_q, z_d;
  logic         pow2_q, pow2_d;
  logic [5:0]   shift_q, shift_d;
  logic         ovf_q, ovf_d;

  logic [64:0]  add_sum;
  logic [63:0]  rem_sh;
  logic         quo_bit;

  assign add_sum = 65'(p_q[127:64]) + (p_q[0] ? 65'(x_q) : 65'd0);
  assign rem_sh  = {p_q[126:64], p_q[63]};
  assign quo_bit = p_q[127] || (rem_sh >= z_q);

  // sequencing of multiply and divide passes
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    p_d     = p_q;
    x_d     = x_q;
    z_d     = z_q;
    pow2_d  = pow2_q;
    shift_d = shift_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          x_d     = x_i;
          z_d     = z_i;
          pow2_d  = pow2_i;
          shift_d = shift_i;
          p_d     = {64'd0, y_i};
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        p_d   = {add_sum, p_q[63:1]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        cnt_d = '0;
        if (z_q == '0 || p_q[127:64] >= z_q) begin
          ovf_d         = 1'b1;
          p_d[63:0]     = Q_LIMIT_L;
          state_d       = S_DONE;
        end else if (pow2_q) begin
          // power-of-two divisor: the quotient is the shifted product
          p_d[63:0] = 64'(p_q >> shift_q);
          state_d   = S_DONE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        p_d   = {quo_bit ? rem_sh - z_q : rem_sh, p_q[62:0], quo_bit};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    p_q     <= p_d;
    x_q     <= x_d;
    z_q     <= z_d;
    pow2_q  <= pow2_d;
    shift_q <= shift_d;
  end

  // quotients above the signed range saturate
  assign done_o = (state_q == S_DONE);
  assign q_o    = p_q[63] ? Q_LIMIT_L : p_q[63:0];
  assign ovf_o  = ovf_q | p_q[63];

endmodule

// ===== src/csfs_datapath.sv =====
// ----------------------------------------------------------------------------
// csfs_datapath: vertex store, segment geometry and field accumulation
// Holds the store, the per-segment registers, norm and divide units, sums.
// ----------------------------------------------------------------------------
module csfs_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  csfs_pkg::in_item_t   item_i,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_data_i,
  input  csfs_pkg::ctrl_cmd_t  cmd_i,
  output csfs_pkg::dp_status_t status_o,
  output csfs_pkg::out_item_t  result_o,
  output logic                 result_valid_o
);

  // shift amounts for the power-of-two divisors
  localparam logic [5:0] SCALE_SHIFT = 6'd40;
  localparam logic [5:0] T_SHIFT     = 6'd30;

  // vertex store
  csfs_pkg::vertex_t store_mem [csfs_pkg::STORE_DEPTH];
  csfs_pkg::vertex_t rd_q;

  logic [csfs_pkg::ADDR_W-1:0] addr_q;
  logic [csfs_pkg::ADDR_W-1:0] rd_addr;
  logic [csfs_pkg::ADDR_W-1:0] wr_addr;
  logic                        wr_ok;

  logic [31:0]       field_scale_q;
  csfs_pkg::vertex_t pt_q;
  csfs_pkg::vertex_t v0_q;
  csfs_pkg::vertex_t v1_q;

  // segment vectors in Q6.26
  logic signed [31:0] sx_q, sy_q, sz_q;
  logic signed [31:0] rx_q, ry_q, rz_q;
  logic signed [31:0] fx_q, fy_q, fz_q;

  // products and their sums
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_d, prod_q;
  logic [3:0]         acc_k;
  logic [63:0]        sql_q, sqa_q, sqb_q;
  logic signed [63:0] cx_q, cy_q, cz_q;

  // norms
  logic [31:0] len_q, a_q, b_q;
  logic [32:0] s_sum;
  logic [33:0] sl_sum;
  logic [32:0] dsl;
  logic        sq_done;
  logic [31:0] sq_root;
  logic [63:0] sq_in;

  // divide chain
  logic [63:0]        md_x, md_y, md_z;
  logic               md_pow2;
  logic [5:0]         md_shift;
  logic               md_done, md_ovf;
  logic [63:0]        md_q;
  logic [63:0]        t_q, q_q;
  logic signed [63:0] crs;
  logic [63:0]        crs_mag;
  logic signed [63:0] term;
  logic signed [63:0] sumx_q, sumy_q, sumz_q;
  logic signed [63:0] sum_sel;
  logic [64:0]        add_res;
  logic               ovf_q, sing_q;

  logic [48:0]         clx, cly, clz;
  csfs_pkg::out_item_t res_q;
  logic                valid_q;

  // store write and read
  assign wr_addr = csfs_pkg::ADDR_W'(32'(item_i.coil_number) * csfs_pkg::VERTS_PER_COIL
                   + 32'(item_i.vertex_number));
  assign wr_ok   = (32'(item_i.coil_number) < csfs_pkg::NUM_COILS) &&
                   (32'(item_i.vertex_number) <= csfs_pkg::SEGMENTS_PER_COIL);
  assign rd_addr = cmd_i.rd_next ? addr_q + csfs_pkg::ADDR_W'(1) : addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wr_ok) begin
      store_mem[wr_addr] <= '{x: item_i.pos_x, y: item_i.pos_y, z: item_i.pos_z};
    end
    rd_q <= store_mem[rd_addr];
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_scale_q <= '0;
    end else if (cfg_we_i) begin
      field_scale_q <= cfg_data_i;
    end
  end

  // segment walk address
  always_ff @(posedge clk_i) begin
    if (cmd_i.query) begin
      addr_q <= '0;
      pt_q   <= '{x: item_i.pos_x, y: item_i.pos_y, z: item_i.pos_z};
    end else if (cmd_i.adv) begin
      addr_q <= addr_q + (cmd_i.adv_skip ? csfs_pkg::ADDR_W'(2) : csfs_pkg::ADDR_W'(1));
    end
    if (cmd_i.latch_v0) begin
      v0_q <= rd_q;
    end
    if (cmd_i.latch_v1) begin
      v1_q <= rd_q;
    end
  end

  // differences cut to Q6.26
  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      sx_q <= csfs_pkg::to_q26(33'(v1_q.x) - 33'(v0_q.x));
      sy_q <= csfs_pkg::to_q26(33'(v1_q.y) - 33'(v0_q.y));
      sz_q <= csfs_pkg::to_q26(33'(v1_q.z) - 33'(v0_q.z));
      rx_q <= csfs_pkg::to_q26(33'(pt_q.x) - 33'(v0_q.x));
      ry_q <= csfs_pkg::to_q26(33'(pt_q.y) - 33'(v0_q.y));
      rz_q <= csfs_pkg::to_q26(33'(pt_q.z) - 33'(v0_q.z));
      fx_q <= csfs_pkg::to_q26(33'(pt_q.x) - 33'(v1_q.x));
      fy_q <= csfs_pkg::to_q26(33'(pt_q.y) - 33'(v1_q.y));
      fz_q <= csfs_pkg::to_q26(33'(pt_q.z) - 33'(v1_q.z));
    end
  end

  // shared multiplier operand order: squares, then cross terms
  always_comb begin
    case (cmd_i.mul_k)
      4'd0:    begin mul_a = sx_q; mul_b = sx_q; end
      4'd1:    begin mul_a = sy_q; mul_b = sy_q; end
      4'd2:    begin mul_a = sz_q; mul_b = sz_q; end
      4'd3:    begin mul_a = rx_q; mul_b = rx_q; end
      4'd4:    begin mul_a = ry_q; mul_b = ry_q; end
      4'd5:    begin mul_a = rz_q; mul_b = rz_q; end
      4'd6:    begin mul_a = fx_q; mul_b = fx_q; end
      4'd7:    begin mul_a = fy_q; mul_b = fy_q; end
      4'd8:    begin mul_a = fz_q; mul_b = fz_q; end
      4'd9:    begin mul_a = sy_q; mul_b = rz_q; end
      4'd10:   begin mul_a = sz_q; mul_b = ry_q; end
      4'd11:   begin mul_a = sz_q; mul_b = rx_q; end
      4'd12:   begin mul_a = sx_q; mul_b = rz_q; end
      4'd13:   begin mul_a = sx_q; mul_b = ry_q; end
      4'd14:   begin mul_a = sy_q; mul_b = rx_q; end
      default: begin mul_a = '0;   mul_b = '0;   end
    endcase
  end

  assign prod_d = mul_a * mul_b;
  assign acc_k  = cmd_i.mul_k - 4'd1;

  // accumulate the product of the previous step
  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      sql_q <= '0;
      sqa_q <= '0;
      sqb_q <= '0;
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= '0;
    end else if (cmd_i.mul_en) begin
      prod_q <= prod_d;
      if (cmd_i.mul_k != 4'd0) begin
        case (acc_k) inside
          4'd0, 4'd1, 4'd2: sql_q <= sql_q + prod_q;
          4'd3, 4'd4, 4'd5: sqa_q <= sqa_q + prod_q;
          4'd6, 4'd7, 4'd8: sqb_q <= sqb_q + prod_q;
          4'd9:             cx_q  <= cx_q + prod_q;
          4'd10:            cx_q  <= cx_q - prod_q;
          4'd11:            cy_q  <= cy_q + prod_q;
          4'd12:            cy_q  <= cy_q - prod_q;
          4'd13:            cz_q  <= cz_q + prod_q;
          4'd14:            cz_q  <= cz_q - prod_q;
          default:          ;
        endcase
      end
    end
  end

  // norms through the shared square root unit
  always_comb begin
    case (cmd_i.sq_sel)
      csfs_pkg::NSEL_LEN: sq_in = sql_q;
      csfs_pkg::NSEL_A:   sq_in = sqa_q;
      default:            sq_in = sqb_q;
    endcase
  end

  csfs_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sq_start),
    .value_i (sq_in),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_ff @(posedge clk_i) begin
    if (sq_done) begin
      case (cmd_i.sq_sel)
        csfs_pkg::NSEL_LEN: len_q <= sq_root;
        csfs_pkg::NSEL_A:   a_q   <= sq_root;
        default:            b_q   <= sq_root;
      endcase
    end
  end

  assign s_sum  = 33'(a_q) + 33'(b_q);
  assign sl_sum = 34'(s_sum) + 34'(len_q);
  assign dsl    = s_sum - 33'(len_q);

  // divide chain operands
  always_comb begin
    case (cmd_i.md_comp)
      csfs_pkg::COMP_X: begin crs = cx_q; sum_sel = sumx_q; end
      csfs_pkg::COMP_Y: begin crs = cy_q; sum_sel = sumy_q; end
      default:          begin crs = cz_q; sum_sel = sumz_q; end
    endcase
    crs_mag  = crs[63] ? 64'(-crs) : 64'(crs);
    md_x     = q_q;
    md_y     = csfs_pkg::P2_26;
    md_z     = 64'(a_q);
    md_pow2  = 1'b0;
    md_shift = '0;
    if (cmd_i.md_tcalc) begin
      md_x = 64'({s_sum, 1'b0});
      md_y = csfs_pkg::P2_30;
      md_z = 64'(sl_sum);
    end else begin
      case (cmd_i.md_stage)
        csfs_pkg::STG_A: begin
          md_x = crs_mag;
        end
        csfs_pkg::STG_B: begin
          md_z = 64'(b_q);
        end
        csfs_pkg::STG_SCALE: begin
          md_y     = 64'(field_scale_q);
          md_z     = csfs_pkg::P2_40;
          md_pow2  = 1'b1;
          md_shift = SCALE_SHIFT;
        end
        csfs_pkg::STG_T: begin
          md_y     = t_q;
          md_z     = csfs_pkg::P2_30;
          md_pow2  = 1'b1;
          md_shift = T_SHIFT;
        end
        default: begin
          md_y = csfs_pkg::P2_13;
          md_z = 64'(dsl);
        end
      endcase
    end
  end

  csfs_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.md_start),
    .x_i     (md_x),
    .y_i     (md_y),
    .z_i     (md_z),
    .pow2_i  (md_pow2),
    .shift_i (md_shift),
    .done_o  (md_done),
    .q_o     (md_q),
    .ovf_o   (md_ovf)
  );

  assign term    = crs[63] ? -$signed(md_q) : $signed(md_q);
  assign add_res = csfs_pkg::sat_add(sum_sel, term);

  always_ff @(posedge clk_i) begin
    if (md_done) begin
      if (cmd_i.md_tcalc) begin
        t_q <= md_q;
      end else begin
        q_q <= md_q;
      end
    end
  end

  // running sums and sticky flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sumx_q <= '0;
      sumy_q <= '0;
      sumz_q <= '0;
      ovf_q  <= 1'b0;
      sing_q <= 1'b0;
    end else if (cmd_i.query) begin
      sumx_q <= '0;
      sumy_q <= '0;
      sumz_q <= '0;
      ovf_q  <= 1'b0;
      sing_q <= 1'b0;
    end else begin
      if (cmd_i.mark_sing) begin
        sing_q <= 1'b1;
      end
      if (md_done) begin
        if (md_ovf) begin
          ovf_q <= 1'b1;
        end
        if (!cmd_i.md_tcalc && cmd_i.md_stage == csfs_pkg::STG_DSL) begin
          if (add_res[64] || md_ovf) begin
            ovf_q <= 1'b1;
          end
          case (cmd_i.md_comp)
            csfs_pkg::COMP_X: sumx_q <= $signed(add_res[63:0]);
            csfs_pkg::COMP_Y: sumy_q <= $signed(add_res[63:0]);
            default:          sumz_q <= $signed(add_res[63:0]);
          endcase
        end
      end
    end
  end

  // result register
  assign clx = csfs_pkg::clamp_out(sumx_q);
  assign cly = csfs_pkg::clamp_out(sumy_q);
  assign clz = csfs_pkg::clamp_out(sumz_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (sing_q) begin
        res_q <= '{field_x: csfs_pkg::OUT_MAX[47:0], field_y: csfs_pkg::OUT_MAX[47:0],
                   field_z: csfs_pkg::OUT_MAX[47:0], status: 1'b1};
      end else begin
        res_q <= '{field_x: clx[47:0], field_y: cly[47:0], field_z: clz[47:0],
                   status: ovf_q | clx[48] | cly[48] | clz[48]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.finish;
    end
  end

  assign status_o.sq_done  = sq_done;
  assign status_o.md_done  = md_done;
  assign status_o.sing_now = (len_q == '0) || (a_q == '0) || (b_q == '0) ||
                             (s_sum <= 33'(len_q));
  assign result_o          = res_q;
  assign result_valid_o    = valid_q;

endmodule

// ===== src/csfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// csfs_ctrl: sequencer for loads and field queries
// Steps the datapath through every segment of every coil, up to a singular one.
// ----------------------------------------------------------------------------
module csfs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 item_cmd_i,
  input  csfs_pkg::dp_status_t status_i,
  output csfs_pkg::ctrl_cmd_t  cmd_o,
  output logic                 busy
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD0  = 4'd1;
  localparam logic [3:0] S_RD1  = 4'd2;
  localparam logic [3:0] S_RD2  = 4'd3;
  localparam logic [3:0] S_DIFF = 4'd4;
  localparam logic [3:0] S_MULS = 4'd5;
  localparam logic [3:0] S_SQS  = 4'd6;
  localparam logic [3:0] S_SQW  = 4'd7;
  localparam logic [3:0] S_CHK  = 4'd8;
  localparam logic [3:0] S_MDS  = 4'd9;
  localparam logic [3:0] S_MDW  = 4'd10;
  localparam logic [3:0] S_NEXT = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  localparam logic [csfs_pkg::SEG_W-1:0] SEG_LAST =
    csfs_pkg::SEG_W'(csfs_pkg::SEGMENTS_PER_COIL - 1);
  localparam logic [csfs_pkg::COIL_W-1:0] COIL_LAST =
    csfs_pkg::COIL_W'(csfs_pkg::NUM_COILS - 1);

  logic [3:0]                  state_q, state_d;
  logic [3:0]                  k_q, k_d;
  logic [1:0]                  nsel_q, nsel_d;
  logic                        tcalc_q, tcalc_d;
  logic [1:0]                  comp_q, comp_d;
  logic [2:0]                  stage_q, stage_d;
  logic [csfs_pkg::SEG_W-1:0]  seg_q, seg_d;
  logic [csfs_pkg::COIL_W-1:0] coil_q, coil_d;
  logic                        accept;

  assign accept = start && (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    nsel_d  = nsel_q;
    tcalc_d = tcalc_q;
    comp_d  = comp_q;
    stage_d = stage_q;
    seg_d   = seg_q;
    coil_d  = coil_q;
    cmd_o          = '0;
    cmd_o.mul_k    = k_q;
    cmd_o.sq_sel   = nsel_q;
    cmd_o.md_tcalc = tcalc_q;
    cmd_o.md_comp  = comp_q;
    cmd_o.md_stage = stage_q;
    cmd_o.adv_skip = (seg_q == SEG_LAST);
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (item_cmd_i == csfs_pkg::CMD_QUERY) begin
            cmd_o.query = 1'b1;
            seg_d       = '0;
            coil_d      = '0;
            state_d     = S_RD0;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_RD0: state_d = S_RD1;
      S_RD1: begin
        cmd_o.rd_next  = 1'b1;
        cmd_o.latch_v0 = 1'b1;
        state_d        = S_RD2;
      end
      S_RD2: begin
        cmd_o.latch_v1 = 1'b1;
        state_d        = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        k_d        = '0;
        state_d    = S_MULS;
      end
      S_MULS: begin
        cmd_o.mul_en = 1'b1;
        k_d          = k_q + 4'd1;
        if (k_q == 4'd15) begin
          nsel_d  = csfs_pkg::NSEL_LEN;
          state_d = S_SQS;
        end
      end
      S_SQS: begin
        cmd_o.sq_start = 1'b1;
        state_d        = S_SQW;
      end
      S_SQW: begin
        if (status_i.sq_done) begin
          if (nsel_q == csfs_pkg::NSEL_B) begin
            state_d = S_CHK;
          end else begin
            nsel_d  = nsel_q + 2'd1;
            state_d = S_SQS;
          end
        end
      end
      S_CHK: begin
        if (status_i.sing_now) begin
          cmd_o.mark_sing = 1'b1;
          state_d         = S_FIN;
        end else begin
          tcalc_d = 1'b1;
          state_d = S_MDS;
        end
      end
      S_MDS: begin
        cmd_o.md_start = 1'b1;
        state_d        = S_MDW;
      end
      S_MDW: begin
        if (status_i.md_done) begin
          state_d = S_MDS;
          if (tcalc_q) begin
            tcalc_d = 1'b0;
            comp_d  = csfs_pkg::COMP_X;
            stage_d = csfs_pkg::STG_A;
          end else if (stage_q == csfs_pkg::STG_DSL) begin
            stage_d = csfs_pkg::STG_A;
            if (comp_q == csfs_pkg::COMP_Z) begin
              state_d = S_NEXT;
            end else begin
              comp_d = comp_q + 2'd1;
            end
          end else begin
            stage_d = stage_q + 3'd1;
          end
        end
      end
      S_NEXT: begin
        cmd_o.adv = 1'b1;
        state_d   = S_RD0;
        if (seg_q == SEG_LAST) begin
          seg_d  = '0;
          coil_d = coil_q + csfs_pkg::COIL_W'(1);
          if (coil_q == COIL_LAST) begin
            state_d = S_FIN;
          end
        end else begin
          seg_d = seg_q + csfs_pkg::SEG_W'(1);
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      nsel_q  <= csfs_pkg::NSEL_LEN;
      tcalc_q <= 1'b0;
      comp_q  <= csfs_pkg::COMP_X;
      stage_q <= csfs_pkg::STG_A;
      seg_q   <= '0;
      coil_q  <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      nsel_q  <= nsel_d;
      tcalc_q <= tcalc_d;
      comp_q  <= comp_d;
      stage_q <= stage_d;
      seg_q   <= seg_d;
      coil_q  <= coil_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== src/coil_segment_field_sum_top.sv =====
// ----------------------------------------------------------------------------
// coil_segment_field_sum_top: field of closed polyline coils at a point
// Stores coil vertices and sums the straight-wire field of every segment.
// ----------------------------------------------------------------------------
//  port group        dir   handshake            payload
//  item input        in    start / busy         item_i (in_item_t)
//  result output     out   result_valid_o       result_o (out_item_t)
//  field scale reg   in    cfg_we_i             cfg_data_i (32 bits)
//
//  a vertex load keeps busy low
//  a query's time is set mostly by the bit-serial multiply-divide unit,
//  run 16 times per segment; its two power-of-two divisions per component
//  are a shift instead of a divide pass
//  a singular segment ends the query early
//  reset clears control, sums and the field scale; the store is not cleared
//  the result strobe lasts one cycle and is never held off
// ----------------------------------------------------------------------------
module coil_segment_field_sum_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  csfs_pkg::in_item_t  item_i,
  output logic                result_valid_o,
  output csfs_pkg::out_item_t result_o,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_data_i
);

  csfs_pkg::ctrl_cmd_t  cmd;
  csfs_pkg::dp_status_t status;

  // sequencer
  csfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .item_cmd_i (item_i.cmd),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  // datapath
  csfs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  // a result follows a busy query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a preceding query");

  // a load transfer never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.cmd == csfs_pkg::CMD_LOAD) |=> !result_valid_o)
    else $error("result after a load");

  // divider cannot finish the cycle after it starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.md_start |=> !status.md_done)
    else $error("divider done too early");

endmodule
